@@ rtl/core/srrip_pkg.sv @@
// Shared types, constants and hash functions for the stream-aware RRIP replacement core.
`timescale 1ns / 1ps
`default_nettype none
package srrip_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int CTR_ENTRIES  = 64;
    localparam int SET_W        = $clog2(NUM_SETS);
    localparam int WAY_W        = $clog2(NUM_WAYS);
    localparam int CTR_W        = $clog2(CTR_ENTRIES);
    localparam int ADDR_W       = 48;
    localparam int PC_W         = 64;
    localparam int SIG_W        = 6;
    localparam int STRIDE_W     = 8;
    localparam int BLOCK_SHIFT  = 6;

    localparam logic OP_VICTIM  = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [1:0] RRV_MAX  = 2'd3;
    localparam logic [1:0] RRV_LONG = 2'd2;
    localparam logic [1:0] RRV_NEAR = 2'd0;
    localparam logic [1:0] CTR_INIT = 2'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_CTR
    } t_state;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_ZERO
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        logic [1:0] operand;
    } t_alu_req;

    typedef struct packed {
        logic [NUM_WAYS-1:0][1:0]       rrv;
        logic [NUM_WAYS-1:0][SIG_W-1:0] sig;
        logic [ADDR_W-1:0]              prev_addr;
        logic [STRIDE_W-1:0]            prev_stride;
        logic [1:0]                     conf;
    } t_set_row;

    localparam t_set_row RESET_ROW = '{
        rrv:         {NUM_WAYS{RRV_LONG}},
        sig:         '0,
        prev_addr:   '0,
        prev_stride: '0,
        conf:        '0
    };

    function automatic logic [SIG_W-1:0] sig_of(input logic [PC_W-1:0] pc);
        sig_of = pc[SIG_W-1:0] ^ pc[11+SIG_W-1:11] ^ pc[17+SIG_W-1:17];
    endfunction

    function automatic logic [CTR_W-1:0] ctr_index(input logic [SIG_W-1:0] sig);
        logic [SIG_W-1:0] h;
        h = sig ^ (sig >> 3);
        ctr_index = h[CTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ship_rrip_stream_aware_replacement_core.sv @@
// Top level: stream-aware RRIP replacement core with set memory and reuse counters.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  request | in  | i_valid / o_ready  | i_op i_set_index i_way i_address i_pc i_hit
//  victim  | out | o_valid / i_ready  | o_victim_way
//
//  A victim item runs a set read, then age/scan/write-back, which stalls while a
//  previous victim way waits at the output. An update item runs a set read, then
//  row write-back with stride tracking, then one reuse-counter write through the
//  shared saturating unit. One item is in flight at a time.
//  After reset a clearing pass writes every set row (and the 64 counters) before
//  the first item is taken.
`timescale 1ns / 1ps
`default_nettype none
module ship_rrip_stream_aware_replacement_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [srrip_pkg::SET_W-1:0]   i_set_index,
    input  wire logic [srrip_pkg::WAY_W-1:0]   i_way,
    input  wire logic [srrip_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [srrip_pkg::PC_W-1:0]    i_pc,
    input  wire logic                          i_hit,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [srrip_pkg::WAY_W-1:0]        o_victim_way
);
    import srrip_pkg::*;

    t_state r_state, n_state;

    t_set_row               r_row_mem [NUM_SETS];
    logic [1:0]             r_ctr_mem [CTR_ENTRIES];
    t_set_row               r_row_q;
    logic [1:0]             r_ctr_q;

    logic [SET_W-1:0]       r_clr_idx;
    logic                   r_op;
    logic [SET_W-1:0]       r_set;
    logic [WAY_W-1:0]       r_way;
    logic [ADDR_W-1:0]      r_addr;
    logic [SIG_W-1:0]       r_sig;
    logic                   r_hit;
    logic [CTR_W-1:0]       r_cidx;
    logic                   r_ovalid;
    logic [WAY_W-1:0]       r_victim;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_clr_last;

    logic                   w_row_re;
    logic [SET_W-1:0]       w_row_ra;
    logic                   w_row_we;
    logic [SET_W-1:0]       w_row_wa;
    t_set_row               w_row_wd;
    logic                   w_ctr_re;
    logic [CTR_W-1:0]       w_ctr_ra;
    logic                   w_ctr_we;
    logic [CTR_W-1:0]       w_ctr_wa;
    logic [1:0]             w_ctr_wd;
    logic                   w_load_out;
    logic                   w_cidx_ld;

    t_alu_req               w_alu_req;
    logic [1:0]             w_alu_res;

    logic                   w_hi;
    logic                   w_lo;
    logic [1:0]             w_add;
    logic [NUM_WAYS-1:0][1:0] w_aged;
    logic [WAY_W-1:0]       w_victim;
    t_set_row               w_victim_row;

    logic [STRIDE_W-1:0]    w_stride;
    logic                   w_match;
    logic [1:0]             w_ins;
    t_set_row               w_update_row;
    logic [CTR_W-1:0]       w_old_idx;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_clr_last = (r_clr_idx == SET_W'(NUM_SETS - 1));

    srrip_sat_unit u_sat (
        .i_req    (w_alu_req),
        .o_result (w_alu_res)
    );

    // victim scan: largest value, aging amount, lowest way at max
    always_comb begin
        w_hi = 1'b0;
        w_lo = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_hi = w_hi | r_row_q.rrv[w][1];
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_lo = w_lo | (r_row_q.rrv[w][0] & (r_row_q.rrv[w][1] | !w_hi));
        end
        w_add = RRV_MAX - {w_hi, w_lo};
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_aged[w] = r_row_q.rrv[w] + w_add;
        end
        w_victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_aged[w] == RRV_MAX) begin
                w_victim = WAY_W'(w);
            end
        end
        w_victim_row     = r_row_q;
        w_victim_row.rrv = w_aged;
    end

    // update path: stride tracking and insertion value
    always_comb begin
        if (r_row_q.prev_addr != '0) begin
            w_stride = r_addr[BLOCK_SHIFT+STRIDE_W-1:BLOCK_SHIFT]
                     - r_row_q.prev_addr[BLOCK_SHIFT+STRIDE_W-1:BLOCK_SHIFT];
        end else begin
            w_stride = '0;
        end
        w_match = (w_stride == r_row_q.prev_stride) && (w_stride != '0);

        priority if (w_alu_res[1] && r_ctr_q <= 2'd1) begin
            w_ins = RRV_MAX;
        end else if (w_alu_res[1] && r_ctr_q == 2'd2) begin
            w_ins = RRV_LONG;
        end else if (r_ctr_q >= 2'd2) begin
            w_ins = RRV_NEAR;
        end else begin
            w_ins = RRV_LONG;
        end

        w_old_idx = ctr_index(r_row_q.sig[r_way]);

        w_update_row             = r_row_q;
        w_update_row.prev_addr   = r_addr;
        w_update_row.prev_stride = w_stride;
        w_update_row.conf        = w_alu_res;
        if (r_hit) begin
            w_update_row.rrv[r_way] = RRV_NEAR;
        end else begin
            w_update_row.rrv[r_way] = w_ins;
            w_update_row.sig[r_way] = r_sig;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (r_op == OP_UPDATE) begin
                    n_state = ST_CTR;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CTR: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        w_row_re   = 1'b0;
        w_row_ra   = i_set_index;
        w_row_we   = 1'b0;
        w_row_wa   = r_set;
        w_row_wd   = w_update_row;
        w_ctr_re   = 1'b0;
        w_ctr_ra   = ctr_index(sig_of(i_pc));
        w_ctr_we   = 1'b0;
        w_ctr_wa   = r_cidx;
        w_ctr_wd   = w_alu_res;
        w_load_out = 1'b0;
        w_cidx_ld  = 1'b0;
        w_alu_req  = '{op: ALU_ZERO, operand: r_row_q.conf};
        unique case (r_state)
            ST_CLEAR: begin
                w_row_we = 1'b1;
                w_row_wa = r_clr_idx;
                w_row_wd = RESET_ROW;
                w_ctr_we = (r_clr_idx < SET_W'(CTR_ENTRIES));
                w_ctr_wa = r_clr_idx[CTR_W-1:0];
                w_ctr_wd = CTR_INIT;
            end
            ST_IDLE: begin
                o_ready  = 1'b1;
                w_row_re = i_valid;
                w_ctr_re = i_valid;
            end
            ST_LOAD: begin
                if (r_op == OP_UPDATE) begin
                    w_alu_req = '{op: (w_match ? ALU_INC : ALU_ZERO), operand: r_row_q.conf};
                    w_row_we  = 1'b1;
                    w_row_wd  = w_update_row;
                    w_ctr_re  = !r_hit;
                    w_ctr_ra  = w_old_idx;
                    w_cidx_ld = !r_hit;
                end else if (w_out_free) begin
                    w_row_we   = 1'b1;
                    w_row_wd   = w_victim_row;
                    w_load_out = 1'b1;
                end
            end
            ST_CTR: begin
                w_alu_req = '{op: (r_hit ? ALU_INC : ALU_DEC), operand: r_ctr_q};
                w_ctr_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + SET_W'(1);
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_set  <= i_set_index;
            r_way  <= i_way;
            r_addr <= i_address;
            r_sig  <= sig_of(i_pc);
            r_hit  <= i_hit;
            r_cidx <= ctr_index(sig_of(i_pc));
        end else if (w_cidx_ld) begin
            r_cidx <= w_old_idx;
        end
        if (w_load_out) r_victim <= w_victim;
    end

    always_ff @(posedge i_clk) begin
        if (w_row_we) r_row_mem[w_row_wa] <= w_row_wd;
        if (w_row_re) r_row_q <= r_row_mem[w_row_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctr_we) r_ctr_mem[w_ctr_wa] <= w_ctr_wd;
        if (w_ctr_re) r_ctr_q <= r_ctr_mem[w_ctr_ra];
    end

    assign o_valid      = r_ovalid;
    assign o_victim_way = r_victim;

    a_update_reaches_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == OP_UPDATE) |-> ##2 (r_state == ST_CTR))
        else $error("update item did not reach counter step");

    a_victim_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (w_aged[w_victim] == RRV_MAX))
        else $error("victim way not at max re-reference value");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_LOAD && r_op == OP_VICTIM))
        else $error("victim output without victim item");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_row_we && !w_ctr_we))
        else $error("memory write while idle");

endmodule
`default_nettype wire

@@ rtl/core/srrip_sat_unit.sv @@
// Shared 2-bit saturating increment / decrement / clear unit.
`timescale 1ns / 1ps
`default_nettype none
module srrip_sat_unit (
    input  srrip_pkg::t_alu_req i_req,
    output logic [1:0]          o_result
);
    import srrip_pkg::*;

    always_comb begin
        unique case (i_req.op)
            ALU_INC:  o_result = (i_req.operand == 2'd3) ? 2'd3 : i_req.operand + 2'd1;
            ALU_DEC:  o_result = (i_req.operand == 2'd0) ? 2'd0 : i_req.operand - 2'd1;
            ALU_ZERO: o_result = 2'd0;
            default:  o_result = i_req.operand;
        endcase
    end

endmodule
`default_nettype wire
